@@ rtl/sample_consensus_filter_top_defines.svh @@
// Assertion macros for the sample consensus filter checker
`ifndef SAMPLE_CONSENSUS_FILTER_TOP_DEFINES_SVH
`define SAMPLE_CONSENSUS_FILTER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define SCF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define SCF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, live through reset
`define SCF_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

@@ rtl/scf_pkg.sv @@
// Package: types, codes and constants of the sample consensus filter
`default_nettype none
package scf_pkg;

  localparam int DEF_MAX_WORDS = 16;
  localparam int DEF_MAX_VARS  = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [2:0] OP_LOAD_SAMPLE = 3'd0;
  localparam logic [2:0] OP_LOAD_VALID  = 3'd1;
  localparam logic [2:0] OP_START       = 3'd2;
  localparam logic [2:0] OP_APPLY       = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;

  localparam logic [1:0] V_NONE      = 2'd0;
  localparam logic [1:0] V_TRUE      = 2'd1;
  localparam logic [1:0] V_FALSE     = 2'd2;
  localparam logic [1:0] V_TOO_FEW   = 2'd3;

  localparam logic [0:0] REG_WORDS_IN_USE = 1'b0;
  localparam logic [0:0] REG_MIN_SURV     = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  variable;
    logic [3:0]  word_index;
    logic [63:0] data_word;
    logic        polarity;
    logic        assigned;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [9:0] queried_variable;
    logic [4:0] surviving_words;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_LOAD_SAMPLE,
    CMD_LOAD_VALID,
    CMD_START,
    CMD_APPLY,
    CMD_QUERY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [9:0]  variable;
    logic [3:0]  word_index;
    logic [63:0] data_word;
    logic        polarity;
    logic        assigned;
    logic        var_ok;
    logic        widx_ok;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_EMIT
  } bk_state_t;

endpackage
`default_nettype wire

@@ rtl/scf_front.sv @@
// Front end: decode and range-check incoming items, drop unused codes
`default_nettype none
module scf_front import scf_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  parameter int MAX_VARS  = DEF_MAX_VARS
) (
  input  in_item_t in_item,
  input  logic     push,
  output logic     full,
  input  logic     q_full,
  output q_wr_t    q_wr,
  output cmd_t     q_cmd
);

  logic    known;
  cmd_op_t op;

  always_comb begin
    known = 1'b1;
    op    = CMD_LOAD_SAMPLE;
    unique case (in_item.operation)
      OP_LOAD_SAMPLE: op = CMD_LOAD_SAMPLE;
      OP_LOAD_VALID:  op = CMD_LOAD_VALID;
      OP_START:       op = CMD_START;
      OP_APPLY:       op = CMD_APPLY;
      OP_QUERY:       op = CMD_QUERY;
      default:        known = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.op         = op;
    q_cmd.variable   = in_item.variable;
    q_cmd.word_index = in_item.word_index;
    q_cmd.data_word  = in_item.data_word;
    q_cmd.polarity   = in_item.polarity;
    q_cmd.assigned   = in_item.assigned;
    q_cmd.var_ok     = (32'(in_item.variable) < 32'(MAX_VARS));
    q_cmd.widx_ok    = (32'(in_item.word_index) < 32'(MAX_WORDS));
  end

  assign full      = q_full;
  assign q_wr.full = q_full;
  assign q_wr.push = push && !q_full && known;

endmodule
`default_nettype wire

@@ rtl/scf_queue.sv @@
// Short command queue between front end and back end
`default_nettype none
module scf_queue import scf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  cmd_t  wr_cmd,
  output logic  q_full,
  input  logic  deq,
  output logic  q_empty,
  output cmd_t  rd_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          ent_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_deq;

  assign q_full  = (32'(cnt_r) == 32'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_cmd  = ent_r[rp_r];
  assign do_deq  = deq && !q_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_wr.push) begin
      wp_nxt = (32'(wp_r) == 32'(DEPTH - 1)) ? '0 : PW'(32'(wp_r) + 1);
    end
    if (do_deq) begin
      rp_nxt = (32'(rp_r) == 32'(DEPTH - 1)) ? '0 : PW'(32'(rp_r) + 1);
    end
    if (q_wr.push && !do_deq) begin
      cnt_nxt = CW'(32'(cnt_r) + 1);
    end else if (!q_wr.push && do_deq) begin
      cnt_nxt = CW'(32'(cnt_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/scf_back.sv @@
// Back end: sample memory, keep mask, word sweeps and result register
`default_nettype none
module scf_back import scf_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  parameter int MAX_VARS  = DEF_MAX_VARS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [4:0] words_in_use,
  input  logic [4:0] min_surviving_words,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      deq,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int AW = $clog2(MAX_VARS * MAX_WORDS);
  localparam int MD = MAX_VARS * MAX_WORDS;

  logic [63:0]   mem [MD];
  logic [63:0]   valid_r [MAX_WORDS];
  logic [63:0]   keep_r  [MAX_WORDS];
  logic [63:0]   rd_data_r;

  bk_state_t     state_r, state_nxt;
  cmd_t          cur_r;
  logic [WW-1:0] iss_r, last_r, p_idx_r;
  logic          iss_done_r, p_valid_r;
  logic [CW-1:0] acc_r, acc_nxt, surv_r, n_w;
  logic          at_r, af_r, at_nxt, af_nxt;
  logic [1:0]    verd_r, verd_nxt;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          take, mem_we, refused, short_q, last_hit, emit_load;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   kw, sv, new_keep;
  logic          nz;

  always_comb begin
    if (words_in_use == 5'd0) begin
      n_w = CW'(1);
    end else if (32'(words_in_use) > 32'(MAX_WORDS)) begin
      n_w = CW'(MAX_WORDS);
    end else begin
      n_w = CW'(words_in_use);
    end
  end

  assign refused  = (32'(surv_r) <= 32'(min_surviving_words));
  assign short_q  = refused || q_cmd.assigned || !q_cmd.var_ok;
  assign last_hit = p_valid_r && (p_idx_r == last_r);
  assign wr_addr  = AW'(32'(q_cmd.variable) * 32'(MAX_WORDS) + 32'(q_cmd.word_index));
  assign rd_addr  = AW'(32'(cur_r.variable) * 32'(MAX_WORDS) + 32'(iss_r));

  // output decode
  always_comb begin
    take      = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      BK_IDLE:  take = !q_empty;
      BK_SWEEP: take = 1'b0;
      BK_EMIT:  emit_load = !out_valid_r || pop;
      default:  take = 1'b0;
    endcase
  end

  assign deq    = take;
  assign mem_we = take && (q_cmd.op == CMD_LOAD_SAMPLE) && q_cmd.var_ok && q_cmd.widx_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          unique case (q_cmd.op)
            CMD_START, CMD_APPLY: state_nxt = BK_SWEEP;
            CMD_QUERY:            state_nxt = short_q ? BK_EMIT : BK_SWEEP;
            default:              state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SWEEP: begin
        if (last_hit) begin
          state_nxt = (cur_r.op == CMD_QUERY) ? BK_EMIT : BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (emit_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // per-word datapath
  always_comb begin
    kw       = keep_r[p_idx_r];
    sv       = rd_data_r & kw;
    new_keep = kw;
    nz       = 1'b0;
    at_nxt   = at_r;
    af_nxt   = af_r;
    case (cur_r.op)
      CMD_START: begin
        new_keep = valid_r[p_idx_r];
        nz = (32'(p_idx_r) < 32'(n_w)) && (valid_r[p_idx_r] != '0);
      end
      CMD_APPLY: begin
        if (cur_r.var_ok) begin
          new_keep = kw & (rd_data_r ^ {64{cur_r.polarity}});
        end
        nz = (new_keep != '0);
      end
      CMD_QUERY: begin
        if (kw != '0) begin
          if (sv != kw) at_nxt = 1'b0;
          if (sv != '0) af_nxt = 1'b0;
        end
      end
      default: nz = 1'b0;
    endcase
    acc_nxt = acc_r + CW'(nz);
    if (at_nxt) begin
      verd_nxt = V_TRUE;
    end else if (af_nxt) begin
      verd_nxt = V_FALSE;
    end else begin
      verd_nxt = V_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.data_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      surv_r      <= '0;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b1;
      p_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= (state_r == BK_SWEEP) && !iss_done_r;
      if (take && state_nxt == BK_SWEEP) begin
        iss_done_r <= 1'b0;
      end else if (state_r == BK_SWEEP && !iss_done_r && iss_r == last_r) begin
        iss_done_r <= 1'b1;
      end
      if (last_hit && cur_r.op != CMD_QUERY) begin
        surv_r <= acc_nxt;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r  <= q_cmd;
      iss_r  <= '0;
      acc_r  <= '0;
      at_r   <= 1'b1;
      af_r   <= 1'b1;
      last_r <= (q_cmd.op == CMD_START) ? WW'(MAX_WORDS - 1) : WW'(32'(n_w) - 1);
      verd_r <= refused ? V_TOO_FEW : V_NONE;
      if (q_cmd.op == CMD_LOAD_VALID && q_cmd.widx_ok) begin
        valid_r[WW'(32'(q_cmd.word_index))] <= q_cmd.data_word;
      end
    end
    if (state_r == BK_SWEEP && !iss_done_r && iss_r != last_r) begin
      iss_r <= iss_r + WW'(1);
    end
    p_idx_r <= iss_r;
    if (p_valid_r) begin
      keep_r[p_idx_r] <= new_keep;
      acc_r           <= acc_nxt;
      at_r            <= at_nxt;
      af_r            <= af_nxt;
      if (last_hit && cur_r.op == CMD_QUERY) begin
        verd_r <= verd_nxt;
      end
    end
    if (emit_load) begin
      out_r.verdict          <= verd_r;
      out_r.queried_variable <= cur_r.variable;
      out_r.surviving_words  <= 5'(surv_r);
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

@@ rtl/sample_consensus_filter_top.sv @@
// Top level of the sample consensus filter: configuration registers and wiring
// Items enter a two-item command queue and the back end takes them one at a time, at the
// earliest in the cycle after they are accepted. A load item is taken without leaving idle.
// Start and apply-literal items, and unrefused query items on a valid, unassigned
// variable, sweep the keep mask one 64-bit word per cycle through the sample memory,
// which has separate write and read ports and whose read is registered. Start sweeps
// all MAX_WORDS words; apply and such a query sweep words_in_use words, clamped to
// 1..MAX_WORDS. Such a query then loads its result into the output register; a refused
// or trivial query goes straight to that load. A query result waits in the output register, so the
// next item is taken while it is unread. A second query waits in its load cycle until
// the first result is popped. No clearing pass is needed after reset.
`default_nettype none
module sample_consensus_filter_top import scf_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  parameter int MAX_VARS  = DEF_MAX_VARS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] words_r, words_nxt, min_r, min_nxt;
  logic       wr_en, q_full, q_empty, deq;
  q_wr_t      q_wr;
  cmd_t       f_cmd, b_cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    words_nxt = words_r;
    min_nxt   = min_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_WORDS_IN_USE: words_nxt = pwdata[4:0];
        REG_MIN_SURV:     min_nxt   = pwdata[4:0];
        default:          words_nxt = words_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= 5'd16;
      min_r   <= 5'd0;
    end else begin
      words_r <= words_nxt;
      min_r   <= min_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WORDS_IN_USE: prdata = {27'd0, words_r};
      REG_MIN_SURV:     prdata = {27'd0, min_r};
      default:          prdata = '0;
    endcase
  end

  scf_front #(.MAX_WORDS(MAX_WORDS), .MAX_VARS(MAX_VARS)) u_front (
    .in_item (in_item),
    .push    (push),
    .full    (full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_cmd   (f_cmd)
  );

  scf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .wr_cmd  (f_cmd),
    .q_full  (q_full),
    .deq     (deq),
    .q_empty (q_empty),
    .rd_cmd  (b_cmd)
  );

  scf_back #(.MAX_WORDS(MAX_WORDS), .MAX_VARS(MAX_VARS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .words_in_use        (words_r),
    .min_surviving_words (min_r),
    .q_empty             (q_empty),
    .q_cmd               (b_cmd),
    .deq                 (deq),
    .empty               (empty),
    .pop                 (pop),
    .out_item            (out_item)
  );

endmodule
`default_nettype wire

@@ rtl/scf_checker.sv @@
// Port-level checker for the sample consensus filter, bound to the top level
`default_nettype none
`include "sample_consensus_filter_top_defines.svh"
module scf_checker import scf_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item,
  input logic      pready
);

  `SCF_ASSERT_RST(a_reset_empty, !rst_n, empty)
  `SCF_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(out_item))
  `SCF_ASSERT_IMP(a_pready_high, 1'b1, pready)
  `SCF_ASSERT_IMP(a_count_bound, !empty, (MAX_WORDS > 31) || (32'(out_item.surviving_words) <= 32'(MAX_WORDS)))

endmodule

bind sample_consensus_filter_top scf_checker #(.MAX_WORDS(MAX_WORDS)) u_scf_checker (.*);
`default_nettype wire
